/* rtl/dds_mip_pkg.sv */
// Package for the DDS mip chain descriptor core.
// Holds header constants, result codes, word widths and the sequencer state type.
// No dependencies; used by dds_mip_len and dds_mip_chain_descriptor_core.
package dds_mip_pkg;

    // header constants
    localparam logic [31:0] HDR_SIGNATURE    = 32'h2053_4444;
    localparam int          FLAG_COUNT_BIT   = 17;   // header_flags 0x20000
    localparam int          PF_FOURCC_BIT    = 2;    // pixel_format_flags 0x4
    localparam logic [31:0] CODE_DXT1        = 32'h3154_5844;
    localparam logic [31:0] CODE_DXT3        = 32'h3354_5844;
    localparam logic [31:0] CODE_DXT5        = 32'h3554_5844;

    // level limits
    localparam int MAX_LEVELS_DEF = 32;
    localparam int RESULT_CAP     = 32;

    // field widths
    localparam int LVL_W  = 5;
    localparam int DIM_W  = 16;
    localparam int WORD_W = 32;

    // stream word widths
    localparam int S_TDATA_W = 224;
    localparam int M_TDATA_W = 104;
    localparam int M_TUSER_W = 4;

    // status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_BAD_MAGIC = 2'd1;
    localparam logic [1:0] ST_NO_FOURCC = 2'd2;
    localparam logic [1:0] ST_BAD_CODE  = 2'd3;

    // texture format codes
    localparam logic [1:0] FMT_NONE = 2'd0;
    localparam logic [1:0] FMT_DXT1 = 2'd1;
    localparam logic [1:0] FMT_DXT3 = 2'd2;
    localparam logic [1:0] FMT_DXT5 = 2'd3;

    // sequencer states, one-hot
    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_DECODE = 4'b0010,
        S_CALC   = 4'b0100,
        S_EMIT   = 4'b1000
    } t_state;

endpackage

/* rtl/dds_mip_len.sv */
// Mip level byte length unit: one multiply per level, result registered.
// len = ((max(4,w)/4) * max(4,h)) / 4 * block_bytes, block_bytes 8 or 16.
// Depends on dds_mip_pkg.
module dds_mip_len (
    input  logic                               i_clk,
    input  logic                               i_en,
    input  logic [dds_mip_pkg::DIM_W-1:0]      i_width,
    input  logic [dds_mip_pkg::DIM_W-1:0]      i_height,
    input  logic                               i_block16,
    output logic [dds_mip_pkg::WORD_W-1:0]     o_len
);

    logic [dds_mip_pkg::DIM_W-1:0] w_clamp;
    logic [dds_mip_pkg::DIM_W-1:0] h_clamp;
    logic [13:0]                   wq;
    logic [29:0]                   prod;
    logic [27:0]                   quads;
    logic [dds_mip_pkg::WORD_W-1:0] r_len;
    logic [dds_mip_pkg::WORD_W-1:0] n_len;

    // clamp to one block, then block columns times rows of pixels
    always_comb begin
        w_clamp = (i_width  < 16'd4) ? 16'd4 : i_width;
        h_clamp = (i_height < 16'd4) ? 16'd4 : i_height;
        wq      = w_clamp[15:2];
        prod    = 30'(wq) * 30'(h_clamp);
        quads   = prod[29:2];
        n_len   = i_block16 ? {quads, 4'b0000} : {1'b0, quads, 3'b000};
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_len <= n_len;
        end
    end

    assign o_len = r_len;

endmodule

/* rtl/dds_mip_chain_descriptor_core.sv */
// Top level of the DDS mip chain descriptor core: header decode and level sequencer.
// Depends on dds_mip_pkg and dds_mip_len.
//
// One header word goes in, and one descriptor word per mip level comes out
// (offset, length, width, height), or a single status word when the header is
// rejected (bad magic, no FourCC flag, or a code other than DXT1/DXT3/DXT5).
// The core handles one header at a time: tready is high only while idle. A
// header passes an accept state and a decode state, then each level goes
// through the shared length multiplier and then onto the output register,
// while a rejected header goes straight to the output register. Output
// backpressure holds the core in its output state. The level count is
// saturated to MAX_LEVELS and to 32. Writing i_cfg_wdata = 0 restricts
// output to the base level; reset value is 1.
module dds_mip_chain_descriptor_core #(
    parameter int MAX_LEVELS = dds_mip_pkg::MAX_LEVELS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // config: load_all_levels
    input  logic                                i_cfg_we,
    input  logic                                i_cfg_wdata,
    // header in
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // magic_word[31:0], header_size[63:32], header_flags[95:64],
    // base_height[111:96], base_width[127:112], level_count_word[159:128],
    // pixel_format_flags[191:160], four_cc[223:192]
    input  logic [dds_mip_pkg::S_TDATA_W-1:0]   i_s_axis_tdata,
    // descriptors out
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    // level_number[4:0], level_width[20:5], level_height[36:21],
    // data_offset[68:37], data_length[100:69], zero[103:101]
    output logic [dds_mip_pkg::M_TDATA_W-1:0]   o_m_axis_tdata,
    // status[1:0], texture_format[3:2]
    output logic [dds_mip_pkg::M_TUSER_W-1:0]   o_m_axis_tuser,
    // last_level
    output logic                                o_m_axis_tlast
);

    localparam int CAP_RAW = (MAX_LEVELS > dds_mip_pkg::RESULT_CAP) ?
                             dds_mip_pkg::RESULT_CAP : MAX_LEVELS;
    localparam int CAP     = (CAP_RAW < 1) ? 1 : CAP_RAW;
    localparam logic [31:0] CAP_WORD = 32'(CAP);

    // control
    dds_mip_pkg::t_state r_state, n_state;
    logic r_load_all;

    // header fields
    logic [31:0] r_magic, n_magic;
    logic [31:0] r_hsize, n_hsize;
    logic [31:0] r_hflags, n_hflags;
    logic [31:0] r_count, n_count;
    logic [31:0] r_pflags, n_pflags;
    logic [31:0] r_fourcc, n_fourcc;

    // level state
    logic [1:0]  r_status, n_status;
    logic [1:0]  r_fmt, n_fmt;
    logic        r_block16, n_block16;
    logic [4:0]  r_level, n_level;
    logic [4:0]  r_last_idx, n_last_idx;
    logic [15:0] r_w, n_w;
    logic [15:0] r_h, n_h;
    logic [31:0] r_off, n_off;

    logic [31:0] len;
    logic [31:0] out_len;
    logic        count_ok;
    logic        is_last;

    // shared length unit, loaded once per level
    dds_mip_len u_len (
        .i_clk     (i_clk),
        .i_en      (r_state == dds_mip_pkg::S_CALC),
        .i_width   (r_w),
        .i_height  (r_h),
        .i_block16 (r_block16),
        .o_len     (len)
    );

    assign is_last  = (r_level == r_last_idx);
    assign count_ok = r_hflags[dds_mip_pkg::FLAG_COUNT_BIT] && r_load_all &&
                      !r_count[31] && (r_count > 32'd1);

    // sequencer next state
    always_comb begin
        n_state    = r_state;
        n_magic    = r_magic;
        n_hsize    = r_hsize;
        n_hflags   = r_hflags;
        n_count    = r_count;
        n_pflags   = r_pflags;
        n_fourcc   = r_fourcc;
        n_status   = r_status;
        n_fmt      = r_fmt;
        n_block16  = r_block16;
        n_level    = r_level;
        n_last_idx = r_last_idx;
        n_w        = r_w;
        n_h        = r_h;
        n_off      = r_off;

        unique case (r_state)
            dds_mip_pkg::S_IDLE: begin
                if (i_s_axis_tvalid) begin
                    n_magic  = i_s_axis_tdata[31:0];
                    n_hsize  = i_s_axis_tdata[63:32];
                    n_hflags = i_s_axis_tdata[95:64];
                    n_h      = i_s_axis_tdata[111:96];
                    n_w      = i_s_axis_tdata[127:112];
                    n_count  = i_s_axis_tdata[159:128];
                    n_pflags = i_s_axis_tdata[191:160];
                    n_fourcc = i_s_axis_tdata[223:192];
                    n_state  = dds_mip_pkg::S_DECODE;
                end
            end
            dds_mip_pkg::S_DECODE: begin
                n_level    = '0;
                n_fmt      = dds_mip_pkg::FMT_NONE;
                n_status   = dds_mip_pkg::ST_OK;
                n_block16  = 1'b1;
                n_off      = r_hsize + 32'd4;
                // saturated level count, stored as index of the last level
                if (!count_ok) begin
                    n_last_idx = '0;
                end else if (r_count >= CAP_WORD) begin
                    n_last_idx = 5'(CAP - 1);
                end else begin
                    n_last_idx = 5'(r_count - 32'd1);
                end
                if (r_magic != dds_mip_pkg::HDR_SIGNATURE) begin
                    n_status = dds_mip_pkg::ST_BAD_MAGIC;
                end else if (!r_pflags[dds_mip_pkg::PF_FOURCC_BIT]) begin
                    n_status = dds_mip_pkg::ST_NO_FOURCC;
                end else if (r_fourcc == dds_mip_pkg::CODE_DXT1) begin
                    n_fmt     = dds_mip_pkg::FMT_DXT1;
                    n_block16 = 1'b0;
                end else if (r_fourcc == dds_mip_pkg::CODE_DXT3) begin
                    n_fmt = dds_mip_pkg::FMT_DXT3;
                end else if (r_fourcc == dds_mip_pkg::CODE_DXT5) begin
                    n_fmt = dds_mip_pkg::FMT_DXT5;
                end else begin
                    n_status = dds_mip_pkg::ST_BAD_CODE;
                end
                if (n_status != dds_mip_pkg::ST_OK) begin
                    // rejected header: one zeroed status word
                    n_last_idx = '0;
                    n_w        = '0;
                    n_h        = '0;
                    n_off      = '0;
                    n_state    = dds_mip_pkg::S_EMIT;
                end else begin
                    n_state = dds_mip_pkg::S_CALC;
                end
            end
            dds_mip_pkg::S_CALC: begin
                n_state = dds_mip_pkg::S_EMIT;
            end
            dds_mip_pkg::S_EMIT: begin
                if (i_m_axis_tready) begin
                    if (is_last) begin
                        n_state = dds_mip_pkg::S_IDLE;
                    end else begin
                        // step to next level: accumulate offset, halve sizes
                        n_off   = r_off + len;
                        n_w     = (r_w[15:1] == 15'd0) ? 16'd1 : {1'b0, r_w[15:1]};
                        n_h     = (r_h[15:1] == 15'd0) ? 16'd1 : {1'b0, r_h[15:1]};
                        n_level = r_level + 5'd1;
                        n_state = dds_mip_pkg::S_CALC;
                    end
                end
            end
            default: begin
                n_state = dds_mip_pkg::S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= dds_mip_pkg::S_IDLE;
            r_load_all <= 1'b1;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_load_all <= i_cfg_wdata;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_magic    <= n_magic;
        r_hsize    <= n_hsize;
        r_hflags   <= n_hflags;
        r_count    <= n_count;
        r_pflags   <= n_pflags;
        r_fourcc   <= n_fourcc;
        r_status   <= n_status;
        r_fmt      <= n_fmt;
        r_block16  <= n_block16;
        r_level    <= n_level;
        r_last_idx <= n_last_idx;
        r_w        <= n_w;
        r_h        <= n_h;
        r_off      <= n_off;
    end

    // output word
    assign out_len         = (r_status == dds_mip_pkg::ST_OK) ? len : '0;
    assign o_s_axis_tready = (r_state == dds_mip_pkg::S_IDLE);
    assign o_m_axis_tvalid = (r_state == dds_mip_pkg::S_EMIT);
    assign o_m_axis_tdata  = {3'b000, out_len, r_off, r_h, r_w, r_level};
    assign o_m_axis_tuser  = {r_fmt, r_status};
    assign o_m_axis_tlast  = is_last;

endmodule

/* verif/dds_mip_chain_descriptor_core_tb.sv */
`timescale 1ns / 100ps
// Testbench for dds_mip_chain_descriptor_core: drives DDS header words, predicts the mip
// descriptors or status word for each one and checks every output word in order.
// Depends on dds_mip_pkg and the core RTL.
module dds_mip_chain_descriptor_core_tb;

    localparam int LIMIT_CYCLES = 1_000_000;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 80;
    localparam int LEVEL_CAP    =
        (dds_mip_pkg::MAX_LEVELS_DEF < dds_mip_pkg::RESULT_CAP) ?
        dds_mip_pkg::MAX_LEVELS_DEF : dds_mip_pkg::RESULT_CAP;

    // one header record as it goes in
    typedef struct {
        logic [31:0] magic;
        logic [31:0] hsize;
        logic [31:0] hflags;
        logic [15:0] height;
        logic [15:0] width;
        logic [31:0] level_count;
        logic [31:0] pf_flags;
        logic [31:0] four_cc;
    } t_header;

    // one descriptor word as it comes out
    typedef struct {
        logic [1:0]  status;
        logic [1:0]  fmt;
        logic [4:0]  level;
        logic [15:0] width;
        logic [15:0] height;
        logic [31:0] offset;
        logic [31:0] length;
        logic        is_last;
    } t_level_desc;

    // expected mip chain per header, checked in order
    class mip_chain_scoreboard;
        t_level_desc expected_q[$];
        bit          load_all;
        int          n_fail;

        function new();
            load_all = 1'b1;
            n_fail   = 0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // append one expected word at the tail
        function void add_expected(t_level_desc d);
            expected_q.insert(expected_q.size(), d);
        endfunction

        // rejected header: one status word, everything else zero
        function void push_reject(logic [1:0] st);
            t_level_desc d;
            d = '{status: st, fmt: dds_mip_pkg::FMT_NONE, level: '0, width: '0,
                  height: '0, offset: '0, length: '0, is_last: 1'b1};
            add_expected(d);
        endfunction

        function void note_header(t_header h);
            logic [1:0]      fmt;
            int unsigned     blk_bytes;
            int unsigned     levels;
            logic [31:0]     offset;
            logic [15:0]     w;
            logic [15:0]     ht;
            longint unsigned wq;
            longint unsigned hm;
            longint unsigned len;
            t_level_desc     d;

            // check order: magic, FourCC flag, then the code
            if (h.magic != dds_mip_pkg::HDR_SIGNATURE) begin
                push_reject(dds_mip_pkg::ST_BAD_MAGIC);
                return;
            end
            if (!h.pf_flags[dds_mip_pkg::PF_FOURCC_BIT]) begin
                push_reject(dds_mip_pkg::ST_NO_FOURCC);
                return;
            end
            case (h.four_cc)
                dds_mip_pkg::CODE_DXT1: begin
                    fmt = dds_mip_pkg::FMT_DXT1; blk_bytes = 8;
                end
                dds_mip_pkg::CODE_DXT3: begin
                    fmt = dds_mip_pkg::FMT_DXT3; blk_bytes = 16;
                end
                dds_mip_pkg::CODE_DXT5: begin
                    fmt = dds_mip_pkg::FMT_DXT5; blk_bytes = 16;
                end
                default: begin
                    push_reject(dds_mip_pkg::ST_BAD_CODE);
                    return;
                end
            endcase

            // signed count, only when flagged and enabled; saturate at the cap
            levels = 1;
            if (h.hflags[dds_mip_pkg::FLAG_COUNT_BIT] && load_all && !h.level_count[31] &&
                h.level_count > 32'd1)
                levels = (h.level_count > LEVEL_CAP) ? LEVEL_CAP : h.level_count;

            offset = h.hsize + 32'd4;
            w      = h.width;
            ht     = h.height;
            for (int i = 0; i < levels; i++) begin
                wq  = ((w < 16'd4) ? 64'd4 : 64'(w)) / 4;
                hm  = (ht < 16'd4) ? 64'd4 : 64'(ht);
                len = (wq * hm) / 4 * blk_bytes;
                d = '{status: dds_mip_pkg::ST_OK, fmt: fmt, level: 5'(i), width: w,
                      height: ht, offset: offset, length: len[31:0],
                      is_last: (i + 1 == levels)};
                add_expected(d);
                offset = offset + len[31:0];
                w  = (w  < 16'd2) ? 16'd1 : w  >> 1;
                ht = (ht < 16'd2) ? 16'd1 : ht >> 1;
            end
        endfunction

        function void check_descriptor(logic [dds_mip_pkg::M_TDATA_W-1:0] data,
                                       logic [dds_mip_pkg::M_TUSER_W-1:0] user,
                                       logic tlast);
            t_level_desc e;
            bit          ok;

            if (expected_q.size() == 0) begin
                n_fail++;
                if (n_fail <= 10)
                    $display("unexpected word: tuser=%h tdata=%h tlast=%b", user, data, tlast);
                return;
            end
            e  = expected_q.pop_front();
            ok = (user[1:0] === e.status) && (user[3:2] === e.fmt) &&
                 (data[4:0] === e.level) && (data[20:5] === e.width) &&
                 (data[36:21] === e.height) && (data[68:37] === e.offset) &&
                 (data[100:69] === e.length) && (data[103:101] === 3'b000) &&
                 (tlast === e.is_last);
            if (!ok) begin
                n_fail++;
                if (n_fail <= 10) begin
                    $display("word mismatch: exp st=%0d fmt=%0d lvl=%0d w=%0d h=%0d",
                             e.status, e.fmt, e.level, e.width, e.height);
                    $display("  exp off=%h len=%h last=%b", e.offset, e.length, e.is_last);
                    $display("  got st=%0d fmt=%0d lvl=%0d w=%0d h=%0d",
                             user[1:0], user[3:2], data[4:0], data[20:5], data[36:21]);
                    $display("  got off=%h len=%h last=%b pad=%b",
                             data[68:37], data[100:69], tlast, data[103:101]);
                end
            end
        endfunction
    endclass

    logic                                 i_clk           = 1'b0;
    logic                                 i_rst_n         = 1'b0;
    logic                                 i_cfg_we        = 1'b0;
    logic                                 i_cfg_wdata     = 1'b0;
    logic                                 i_s_axis_tvalid = 1'b0;
    logic                                 o_s_axis_tready;
    // magic, header_size, header_flags, base_height, base_width,
    // level_count_word, pixel_format_flags, four_cc
    logic [dds_mip_pkg::S_TDATA_W-1:0]    i_s_axis_tdata  = '0;
    logic                                 o_m_axis_tvalid;
    logic                                 i_m_axis_tready = 1'b0;
    // level_number, level_width, level_height, data_offset, data_length, zero pad
    logic [dds_mip_pkg::M_TDATA_W-1:0]    o_m_axis_tdata;
    // status, texture_format
    logic [dds_mip_pkg::M_TUSER_W-1:0]    o_m_axis_tuser;
    logic                                 o_m_axis_tlast;

    mip_chain_scoreboard sb = new();
    bit quiet    = 1'b0;   // no idling on either side
    bit hold_req = 1'b0;   // asks the sink for one long hold-off
    int cycles   = 0;

    dds_mip_chain_descriptor_core dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES) begin
            $display("dds_mip_chain_descriptor_core: mismatch");
            $finish;
        end
    end

    // output monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready)
            sb.check_descriptor(o_m_axis_tdata, o_m_axis_tuser, o_m_axis_tlast);
    end

    // sink ready: random stalls, one long hold-off on request
    initial begin : sink_ready
        int unsigned n;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                i_m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else if (!quiet && $urandom_range(0, 2) == 0) begin
                i_m_axis_tready <= 1'b0;
                n = $urandom_range(1, 9);
                repeat (n) @(posedge i_clk);
            end else begin
                i_m_axis_tready <= 1'b1;
                n = $urandom_range(1, 16);
                repeat (n) @(posedge i_clk);
            end
        end
    end

    // offer one header word and hold it until accepted; maybe idle after
    task automatic send_header(input t_header h);
        i_s_axis_tdata  <= {h.four_cc, h.pf_flags, h.level_count, h.width, h.height,
                            h.hflags, h.hsize, h.magic};
        i_s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (o_s_axis_tready !== 1'b1);
        sb.note_header(h);
        if (!quiet && $urandom_range(0, 2) == 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge i_clk);
        end
    endtask

    // stop offering and wait for every expected word
    task automatic drain();
        i_s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    task automatic write_load_all(input bit v);
        drain();
        repeat (4) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        sb.load_all = v;
    endtask

    function automatic t_header dxt_header(logic [31:0] code, logic [31:0] count,
                                           logic [15:0] w, logic [15:0] ht);
        t_header h;
        h.magic       = dds_mip_pkg::HDR_SIGNATURE;
        h.hsize       = 32'd124;
        h.hflags      = 32'h000A_1007;
        h.height      = ht;
        h.width       = w;
        h.level_count = count;
        h.pf_flags    = 32'h0000_0004;
        h.four_cc     = code;
        return h;
    endfunction

    function automatic logic [15:0] random_dim();
        case ($urandom_range(0, 2))
            0:       return 16'($urandom_range(0, 40));
            1:       return 16'($urandom_range(0, 65535));
            default: return 16'd1 << $urandom_range(0, 15);
        endcase
    endfunction

    // mostly well-formed DXT headers, some broken ones
    function automatic t_header random_header();
        t_header     h;
        int unsigned pick;
        h.magic  = dds_mip_pkg::HDR_SIGNATURE;
        h.hsize  = ($urandom_range(0, 3) == 0) ? $urandom : 32'd124;
        h.hflags = $urandom;
        if ($urandom_range(0, 7) != 0)
            h.hflags[dds_mip_pkg::FLAG_COUNT_BIT] = 1'b1;
        h.height = random_dim();
        h.width  = random_dim();
        pick = $urandom_range(0, 19);
        if (pick < 14)
            h.level_count = $urandom_range(0, 12);
        else if (pick < 17)
            h.level_count = $urandom_range(13, 40);
        else if (pick < 19)
            h.level_count = $urandom;
        else
            h.level_count = -32'($urandom_range(1, 5));
        h.pf_flags = $urandom | 32'h4;
        case ($urandom_range(0, 2))
            0:       h.four_cc = dds_mip_pkg::CODE_DXT1;
            1:       h.four_cc = dds_mip_pkg::CODE_DXT3;
            default: h.four_cc = dds_mip_pkg::CODE_DXT5;
        endcase
        // noise
        pick = $urandom_range(0, 19);
        case (pick)
            0: h.magic = $urandom;
            1: h.magic[$urandom_range(0, 31)] = ~h.magic[0];
            2: h.magic = h.magic ^ (32'd1 << $urandom_range(0, 31));
            3: h.pf_flags[dds_mip_pkg::PF_FOURCC_BIT] = 1'b0;
            4: h.four_cc = $urandom;
            5: h.four_cc[31:24] = h.four_cc[31:24] ^ 8'($urandom_range(1, 255));
            default: ;
        endcase
        return h;
    endfunction

    task automatic random_phase(input int n_items, input int hold_at, input int pause_at);
        for (int i = 0; i < n_items; i++) begin
            if (i == hold_at)
                hold_req = 1'b1;
            if (i == pause_at)
                drain();
            send_header(random_header());
        end
    endtask

    // main stimulus
    initial begin : stimulus
        t_header h;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        write_load_all(1'b1);

        // rejects and their precedence
        h = dxt_header(dds_mip_pkg::CODE_DXT1, 32'd4, 16'd64, 16'd64);
        h.magic = 32'h0;
        send_header(h);
        h.magic = 32'hFFFF_FFFF;
        h.pf_flags = 32'h0;
        send_header(h);
        h = dxt_header(32'h3454_5844, 32'd4, 16'd64, 16'd64);
        h.pf_flags = 32'hFFFF_FFFB;
        send_header(h);
        h.pf_flags = 32'hFFFF_FFFF;
        send_header(h);
        send_header(dxt_header(32'h0, 32'd4, 16'd64, 16'd64));

        // each format, full and saturated chains
        send_header(dxt_header(dds_mip_pkg::CODE_DXT1, 32'd9, 16'd256, 16'd256));
        send_header(dxt_header(dds_mip_pkg::CODE_DXT3, 32'd32, 16'hFFFF, 16'hFFFF));
        send_header(dxt_header(dds_mip_pkg::CODE_DXT5, 32'd33, 16'd1, 16'd1));
        send_header(dxt_header(dds_mip_pkg::CODE_DXT1, 32'h7FFF_FFFF, 16'd512, 16'd128));
        // count of zero, one and negative means one level
        send_header(dxt_header(dds_mip_pkg::CODE_DXT3, 32'h8000_0000, 16'd32, 16'd32));
        send_header(dxt_header(dds_mip_pkg::CODE_DXT5, 32'hFFFF_FFFF, 16'd32, 16'd32));
        send_header(dxt_header(dds_mip_pkg::CODE_DXT1, 32'd0, 16'd32, 16'd32));
        send_header(dxt_header(dds_mip_pkg::CODE_DXT3, 32'd1, 16'd32, 16'd32));
        // zero and tiny base sizes
        send_header(dxt_header(dds_mip_pkg::CODE_DXT1, 32'd4, 16'd0, 16'd0));
        send_header(dxt_header(dds_mip_pkg::CODE_DXT5, 32'd3, 16'd3, 16'd2));
        send_header(dxt_header(dds_mip_pkg::CODE_DXT5, 32'd18, 16'hFFFF, 16'd1));
        // offset wrap
        h = dxt_header(dds_mip_pkg::CODE_DXT3, 32'd5, 16'd1024, 16'd1024);
        h.hsize = 32'hFFFF_FFFF;
        send_header(h);
        // count not flagged
        h = dxt_header(dds_mip_pkg::CODE_DXT1, 32'd8, 16'd128, 16'd128);
        h.hflags = 32'hFFFD_FFFF;
        send_header(h);

        random_phase(150, 40, -1);

        // base level only
        write_load_all(1'b0);
        send_header(dxt_header(dds_mip_pkg::CODE_DXT3, 32'd10, 16'd256, 16'd64));
        send_header(dxt_header(dds_mip_pkg::CODE_DXT5, 32'd32, 16'hFFFF, 16'hFFFF));
        random_phase(100, -1, 50);

        // back to full chains, no idling
        write_load_all(1'b1);
        quiet = 1'b1;
        random_phase(150, -1, -1);

        drain();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.n_fail == 0 && sb.pending() == 0)
            $display("dds_mip_chain_descriptor_core: match");
        else
            $display("dds_mip_chain_descriptor_core: mismatch");
        $finish;
    end

endmodule

/* filelist.f */
rtl/dds_mip_pkg.sv
rtl/dds_mip_len.sv
rtl/dds_mip_chain_descriptor_core.sv
verif/dds_mip_chain_descriptor_core_tb.sv
